FILE: sv/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared types and constants of the lru page replacement block
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // number of page frames and width of a page number
  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;

  localparam int CFG_W = 4;
  localparam int CNT_W = 32;
  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAMES);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_BUSY
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming reference
    logic commit;  // update frames and counters, write result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_blocked;  // result register holds a result that is not taken this cycle
  } status_t;

  // usable frames: zero acts as one, values above FRAMES act as FRAMES
  function automatic logic [OCC_W-1:0] capacity(input logic [CFG_W-1:0] cfg);
    logic [OCC_W-1:0] cap;
    if (cfg == '0) begin
      cap = OCC_W'(1);
    end else if (int'(cfg) > FRAMES) begin
      cap = OCC_W'(FRAMES);
    end else begin
      cap = OCC_W'(cfg);
    end
    return cap;
  endfunction

endpackage

FILE: sv/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// lrupr_ctrl
// controller: takes one reference at a time and commits it when the result
// register can take the result
// ----------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lrupr_pkg::status_t status_i,
  output lrupr_pkg::cmd_t    cmd_o
);

  lrupr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrupr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrupr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lrupr_pkg::ST_BUSY;
        end
      end
      lrupr_pkg::ST_BUSY: begin
        if (!status_i.out_blocked) begin
          state_d = lrupr_pkg::ST_IDLE;
        end
      end
      default: state_d = lrupr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      lrupr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      lrupr_pkg::ST_BUSY: begin
        cmd_o.commit = !status_i.out_blocked;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a commit only follows a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> state_q == lrupr_pkg::ST_BUSY)
    else $error("commit outside busy state");

  // a transfer in is followed by a busy cycle with the input stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o)
    else $error("input not stalled after load");

  // a blocked result register holds the commit back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.out_blocked |-> !cmd_o.commit)
    else $error("commit while result register blocked");
`endif

endmodule

FILE: sv/lrupr_datapath.sv
// ----------------------------------------------------------------------------
// lrupr_datapath
// datapath: frame line in recency order, parallel page compare, recency
// shift, saturating counters and the result register
// ----------------------------------------------------------------------------
module lrupr_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lrupr_pkg::cmd_t                    cmd_i,
  output lrupr_pkg::status_t                 status_o,
  input  logic [15:0]                        page_number_i,
  input  logic                               cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic                               evicted_valid_o,
  output logic [15:0]                        evicted_page_o,
  output logic [31:0]                        fault_total_o,
  output logic [31:0]                        hit_total_o
);

  localparam int FR = lrupr_pkg::FRAMES;
  localparam int PB = lrupr_pkg::PAGE_BITS;
  localparam int OW = lrupr_pkg::OCC_W;
  localparam int IW = lrupr_pkg::IDX_W;
  localparam int CW = lrupr_pkg::CNT_W;

  // configuration
  logic [lrupr_pkg::CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lrupr_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // captured reference
  logic [PB-1:0] page_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_number_i[PB-1:0];
    end
  end

  // frame line, entry 0 least recent, valid entries packed from entry 0
  logic [PB-1:0] frame_q [FR];
  logic [PB-1:0] frame_d [FR];
  logic [OW-1:0] occ_q, occ_d;
  logic [CW-1:0] fault_cnt_q, fault_cnt_d;
  logic [CW-1:0] hit_cnt_q, hit_cnt_d;

  // parallel compare, lowest matching entry wins
  logic          found;
  logic [IW-1:0] where;

  always_comb begin
    found = 1'b0;
    where = '0;
    for (int i = FR - 1; i >= 0; i--) begin
      if (OW'(i) < occ_q && frame_q[i] == page_q) begin
        found = 1'b1;
        where = IW'(i);
      end
    end
  end

  logic [OW-1:0] cap;
  logic          evict;
  logic          shift;     // remove one entry and append at the top of the line
  logic [OW-1:0] rm_idx;

  assign cap    = lrupr_pkg::capacity(cfg_q);
  assign evict  = !found && (occ_q >= cap);
  assign shift  = found || evict;
  assign rm_idx = found ? OW'(where) : '0;

  for (genvar g = 0; g < FR; g++) begin : g_frame
    logic [PB-1:0] upper;
    if (g + 1 < FR) begin : g_up
      assign upper = frame_q[g+1];
    end else begin : g_top
      assign upper = frame_q[g];
    end

    always_comb begin
      frame_d[g] = frame_q[g];
      if (shift) begin
        if (OW'(g + 1) == occ_q) begin
          frame_d[g] = page_q;
        end else if (OW'(g) >= rm_idx && OW'(g + 1) < occ_q) begin
          frame_d[g] = upper;
        end
      end else if (OW'(g) == occ_q) begin
        frame_d[g] = page_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        frame_q[g] <= frame_d[g];
      end
    end
  end

  always_comb begin
    occ_d       = occ_q;
    fault_cnt_d = fault_cnt_q;
    hit_cnt_d   = hit_cnt_q;
    if (found) begin
      if (hit_cnt_q != lrupr_pkg::CNT_MAX) begin
        hit_cnt_d = hit_cnt_q + CW'(1);
      end
    end else begin
      if (fault_cnt_q != lrupr_pkg::CNT_MAX) begin
        fault_cnt_d = fault_cnt_q + CW'(1);
      end
      if (!evict) begin
        occ_d = occ_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      fault_cnt_q <= '0;
      hit_cnt_q   <= '0;
    end else if (cmd_i.commit) begin
      occ_q       <= occ_d;
      fault_cnt_q <= fault_cnt_d;
      hit_cnt_q   <= hit_cnt_d;
    end
  end

  // result register
  logic          out_valid_q;
  logic          out_hit_q;
  logic          out_ev_valid_q;
  logic [PB-1:0] out_ev_page_q;
  logic [CW-1:0] out_fault_q;
  logic [CW-1:0] out_hits_q;

  assign status_o.out_blocked = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_q      <= found;
      out_ev_valid_q <= evict;
      out_ev_page_q  <= evict ? frame_q[0] : '0;
      out_fault_q    <= fault_cnt_d;
      out_hits_q     <= hit_cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = 16'(out_ev_page_q);
  assign fault_total_o   = out_fault_q;
  assign hit_total_o     = out_hits_q;

`ifndef SYNTHESIS
  // occupancy never exceeds the frame count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= FR)
    else $error("occupancy above frame count");

  // a commit always presents a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("result missing after commit");

  // an eviction only ever comes from a fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_ev_valid_q))
    else $error("eviction reported on a hit");

  // occupancy only grows on a fault that evicts nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && shift |=> $stable(occ_q))
    else $error("occupancy changed on hit or eviction");
`endif

endmodule

FILE: sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative lru page-frame tracker with fault and hit counters
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one page reference. The block keeps
// up to FRAMES resident pages in recency order and compares the reference
// against all of them at once. On a hit the page moves to most recent and the
// hit count grows; on a fault the fault count grows and the page goes in as
// most recent, evicting and reporting the least recent page once the occupied
// frames reach frames_in_use (0 acts as 1, values above FRAMES act as FRAMES).
// Lowering frames_in_use never drops pages by itself: later faults evict one
// page each, so occupancy stays put. Both counters stop at all ones. Frames
// start empty after reset and there is no clearing pass. A reference is captured
// in the idle state; in the busy state the compare, the recency shift and the
// counters commit into the result register, and no new reference is taken
// before that commit. The result register lets the next reference be captured
// while the previous result still waits; the commit waits as long as that result
// is held by out_stall_i.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  // reference channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] page_number_i,
  // frames_in_use register
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_page_o,
  output logic [31:0] fault_total_o,
  output logic [31:0] hit_total_o
);

  // command and status between controller and datapath
  lrupr_pkg::cmd_t    cmd;
  lrupr_pkg::status_t status;

  // controller: idle / busy sequencing of one reference at a time
  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: frame line, compare, shift, counters, result register
  lrupr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .page_number_i   (page_number_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o),
    .hit_total_o     (hit_total_o)
  );

endmodule

FILE: sim/lru_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_checker
// predicts every result of lru_page_replacement and compares it on transfer
// ----------------------------------------------------------------------------
// Watches the reference channel, the frames_in_use port and the result
// channel. Each accepted reference runs through a private copy of the recency
// list and counters; the outcome is queued and checked field by field against
// the next accepted result. Counts failures for the testbench top.
// ----------------------------------------------------------------------------
module lru_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] page_number_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        hit_i,
  input  logic        evicted_valid_i,
  input  logic [15:0] evicted_page_i,
  input  logic [31:0] fault_total_i,
  input  logic [31:0] hit_total_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;
    logic [31:0] hit_total;
  } page_outcome_t;

  // resident pages, entry 0 least recent, packed from entry 0
  logic [lrupr_pkg::PAGE_BITS-1:0] recency_page [lrupr_pkg::FRAMES];
  int                              resident_count;
  logic [lrupr_pkg::CFG_W-1:0]     frames_setting;
  logic [lrupr_pkg::CNT_W-1:0]     fault_tally;
  logic [lrupr_pkg::CNT_W-1:0]     hit_tally;
  page_outcome_t                   outcome_q [$];

  function automatic page_outcome_t lru_outcome(input logic [15:0] page);
    logic [lrupr_pkg::PAGE_BITS-1:0] key;
    int                              usable;
    int                              where;
    bit                              found;
    page_outcome_t                   res;
    key = page[lrupr_pkg::PAGE_BITS-1:0];
    // zero acts as one frame, anything above FRAMES as FRAMES
    if (frames_setting == '0) begin
      usable = 1;
    end else if (int'(frames_setting) > lrupr_pkg::FRAMES) begin
      usable = lrupr_pkg::FRAMES;
    end else begin
      usable = int'(frames_setting);
    end
    found = 1'b0;
    where = 0;
    res   = '0;
    for (int i = 0; i < resident_count; i++) begin
      if (!found && recency_page[i] == key) begin
        found = 1'b1;
        where = i;
      end
    end
    if (found) begin
      if (hit_tally != lrupr_pkg::CNT_MAX) hit_tally++;
      for (int i = where; i + 1 < resident_count; i++) recency_page[i] = recency_page[i + 1];
      recency_page[resident_count - 1] = key;
    end else begin
      if (fault_tally != lrupr_pkg::CNT_MAX) fault_tally++;
      // occupancy above the setting still evicts only one page
      if (resident_count >= usable) begin
        res.evicted_valid = 1'b1;
        res.evicted_page  = 16'(recency_page[0]);
        for (int i = 0; i + 1 < resident_count; i++) recency_page[i] = recency_page[i + 1];
        recency_page[resident_count - 1] = key;
      end else begin
        recency_page[resident_count] = key;
        resident_count++;
      end
    end
    res.hit         = found;
    res.fault_total = fault_tally;
    res.hit_total   = hit_tally;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_outcome_t want;
    if (!rst_ni) begin
      resident_count = 0;
      frames_setting = lrupr_pkg::CFG_RESET;
      fault_tally    = '0;
      hit_tally      = '0;
      outcome_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no reference outstanding");
          mismatch_count_o++;
        end else begin
          want = outcome_q.pop_front();
          if (hit_i !== want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, hit_i);
            mismatch_count_o++;
          end
          if (evicted_valid_i !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d actual %0d", want.evicted_valid,
                   evicted_valid_i);
            mismatch_count_o++;
          end
          if (evicted_page_i !== want.evicted_page) begin
            $error("evicted_page: expected %h actual %h", want.evicted_page, evicted_page_i);
            mismatch_count_o++;
          end
          if (fault_total_i !== want.fault_total) begin
            $error("fault_total: expected %0d actual %0d", want.fault_total, fault_total_i);
            mismatch_count_o++;
          end
          if (hit_total_i !== want.hit_total) begin
            $error("hit_total: expected %0d actual %0d", want.hit_total, hit_total_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        outcome_q.insert(outcome_q.size(), lru_outcome(page_number_i));
      end
      if (cfg_we_i) frames_setting = cfg_data_i;
    end
    pending_count_o = outcome_q.size();
  end

endmodule

FILE: sim/tb_lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// self-checking testbench of the lru page-frame tracker
// ----------------------------------------------------------------------------
// Drives page references and frames_in_use settings, idles both channels at
// random and holds the result channel off twice for a long stretch so the
// block backs up. A directed pass covers page extremes, hits, faults with and
// without eviction, the out-of-range settings and a setting lowered while all
// frames are full; random phases then replay small working sets under
// several settings. lru_frame_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 163;
  localparam int HOLD_OFF_CYCLES = 300;
  // a reference is captured and then committed inside the block; leave some slack
  localparam int DRAIN_CYCLES    = 6;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int POOL_MAX        = 12;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [15:0]                 page_number   = '0;
  logic                        cfg_we        = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0] cfg_data      = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic                        hit;
  logic                        evicted_valid;
  logic [15:0]                 evicted_page;
  logic [31:0]                 fault_total;
  logic [31:0]                 hit_total;

  int mismatches;
  int pending;
  int cycle_count  = 0;

  // idle odds in percent, changed per phase by the stimulus process
  int src_idle_pct  = 29;
  int sink_idle_pct = 79;
  bit hold_off_req  = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  lru_page_replacement uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .page_number_i  (page_number),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_o          (hit),
    .evicted_valid_o(evicted_valid),
    .evicted_page_o (evicted_page),
    .fault_total_o  (fault_total),
    .hit_total_o    (hit_total)
  );

  lru_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .page_number_i   (page_number),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .hit_i           (hit),
    .evicted_valid_i (evicted_valid),
    .evicted_page_i  (evicted_page),
    .fault_total_i   (fault_total),
    .hit_total_i     (hit_total),
    .mismatch_count_o(mismatches),
    .pending_count_o (pending)
  );

  // one page reference; optional idle gap first, returns right after the transfer
  // with valid still high, so the next call lowers or reloads it exactly once
  task automatic reference_page(input logic [15:0] pg);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    page_number <= pg;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // frames_in_use only changes with the block idle
  task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] setting);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= setting;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off when asked for
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // watchdog: a run that hangs or never drains fails here
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [lrupr_pkg::CFG_W-1:0] phase_setting [PHASES];
    logic [15:0]                 pool [POOL_MAX];
    int                          pool_size;
    logic [15:0]                 pg;

    phase_setting = '{4'd8, 4'd2, 4'd9, 4'd5, 4'd0, 4'd4,
                      4'd15, 4'd7, 4'd1, 4'd6, 4'd3, 4'd12};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero acts as a single frame: fill, hit, then each fault evicts the only page
    write_frames('0);
    reference_page(16'h0000);
    reference_page(16'h0000);
    reference_page(16'hFFFF);
    reference_page(16'hFFFF);
    reference_page(16'h0000);

    write_frames(4'd1);
    reference_page(16'hA5A5);
    reference_page(16'h5A5A);

    // grow to three frames, hit on an older page, then evict
    write_frames(4'd3);
    reference_page(16'h0001);
    reference_page(16'h0002);
    reference_page(16'h5A5A);
    reference_page(16'h0004);

    // above FRAMES acts as FRAMES: fill every frame, then evict twice
    write_frames(4'd15);
    reference_page(16'h8000);
    reference_page(16'h4000);
    reference_page(16'h2000);
    reference_page(16'h1000);
    reference_page(16'h0800);
    reference_page(16'h0003);
    reference_page(16'h0002);

    // lowered while full: old pages still hit, a fault evicts only one page
    write_frames(4'd2);
    reference_page(16'h8000);
    reference_page(16'h7777);

    // random phases over small working sets, idle pattern changes every four
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 4)
        0: begin
          src_idle_pct  = 29;
          sink_idle_pct = 79;
        end
        1: begin
          src_idle_pct  = 79;
          sink_idle_pct = 29;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      write_frames(phase_setting[ph]);
      pool_size = $urandom_range(2, POOL_MAX);
      for (int k = 0; k < pool_size; k++) pool[k] = 16'($urandom);
      // long receiver hold-off while references keep coming
      if (ph == 2 || ph == 9) hold_off_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(9) == 0) begin
          pg = 16'($urandom);
        end else begin
          pg = pool[$urandom_range(0, pool_size - 1)];
        end
        reference_page(pg);
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
